// ----- design/adpcm_nibble_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// ADPCM nibble decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ADPCM_NIBBLE_DECODER_MACROS_SVH
`define ADPCM_NIBBLE_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADND_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adpcm nibble decoder: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ADND_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adpcm nibble decoder: assertion failed");

`endif

// ----- design/adnd_pkg.sv -----
// ----------------------------------------------------------------------------
// ADPCM nibble decoder package
// Widths, limits, the step adaptation table and the types shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package adnd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int STEP_W     = 15;
    localparam int CODE_W     = 4;
    localparam int BYTE_W     = 8;
    localparam int FACTOR_W   = 16;
    localparam int STEP_SHIFT = 14;

    localparam logic [STEP_W-1:0] STEP_MIN = 15'd127;
    localparam logic [STEP_W-1:0] STEP_MAX = 15'd24576;

    localparam int CODE_QUEUE_DEPTH_DEF   = 4;
    localparam int RESULT_QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic              restart;
        logic              last;
        logic [CODE_W-1:0] code;
    } code_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } result_t;

    function automatic logic [FACTOR_W-1:0] step_factor(input logic [2:0] idx);
        logic [FACTOR_W-1:0] f;
        case (idx)
            3'd4:    f = 16'h4CC0;
            3'd5:    f = 16'h6640;
            3'd6:    f = 16'h8000;
            3'd7:    f = 16'h9980;
            default: f = 16'h3980;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ----- design/adnd_fifo.sv -----
// ----------------------------------------------------------------------------
// ADPCM nibble decoder queue
// Small register queue with full and empty flags, first-word fall-through.
// ----------------------------------------------------------------------------
`default_nettype none

module adnd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ----- design/adnd_front.sv -----
// ----------------------------------------------------------------------------
// ADPCM nibble decoder front end
// Accepts code bytes and splits each into one or two code items.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adpcm_nibble_decoder_macros.svh"

module adnd_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [adnd_pkg::BYTE_W-1:0]   code_byte,
    input  wire logic                          high_only,
    input  wire logic                          restart,
    output logic                               cq_push,
    output adnd_pkg::code_item_t               cq_item,
    input  wire logic                          cq_full
);

    import adnd_pkg::*;

    logic              pend_valid_reg, pend_valid_next;
    logic [CODE_W-1:0] pend_code_reg;
    logic              accept;
    logic              pend_send;

    assign full      = pend_valid_reg || cq_full;
    assign accept    = push && !full;
    assign pend_send = pend_valid_reg && !cq_full;
    assign cq_push   = accept || pend_send;

    always_comb
    begin
        if (pend_valid_reg)
        begin
            cq_item.restart = 1'b0;
            cq_item.last    = 1'b1;
            cq_item.code    = pend_code_reg;
        end
        else
        begin
            cq_item.restart = restart;
            cq_item.last    = high_only;
            cq_item.code    = code_byte[BYTE_W-1:CODE_W];
        end
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (accept)
        begin
            pend_valid_next = !high_only;
        end
        else if (pend_send)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_code_reg <= code_byte[CODE_W-1:0];
        end
    end

    `ADND_ASSERT_NEXT(a_pend_after_pair, accept && !high_only, pend_valid_reg)
    `ADND_ASSERT_NEXT(a_pend_drains, pend_send, !pend_valid_reg)
    `ADND_ASSERT_NEXT(a_pend_held, pend_valid_reg && cq_full, pend_valid_reg)

endmodule

`default_nettype wire

// ----- design/adnd_core.sv -----
// ----------------------------------------------------------------------------
// ADPCM nibble decoder back end
// Decodes one code per cycle (if queued and result queue not full) against the predictor and adapts the step size.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adpcm_nibble_decoder_macros.svh"

module adnd_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire adnd_pkg::code_item_t  cq_item,
    input  wire logic                  cq_empty,
    output logic                       cq_pop,
    output logic                       rq_push,
    output adnd_pkg::result_t          rq_item,
    input  wire logic                  rq_full
);

    import adnd_pkg::*;

    localparam int SUM_W = SAMPLE_W + 2;
    localparam int PROD_W = STEP_W + FACTOR_W;
    localparam int SCALED_W = PROD_W - STEP_SHIFT;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 18'sd32767;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -18'sd32768;

    logic signed [SAMPLE_W-1:0] pred_reg, pred_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic                       consume;
    logic [STEP_W-1:0]          s;
    logic signed [SAMPLE_W-1:0] p;
    logic [SAMPLE_W-1:0]        mag;
    logic signed [SUM_W-1:0]    delta;
    logic signed [SUM_W-1:0]    sum;
    logic [PROD_W-1:0]          prod;
    logic [SCALED_W-1:0]        scaled;

    assign consume = !cq_empty && !rq_full;
    assign cq_pop  = consume;
    assign rq_push = consume;

    assign s = cq_item.restart ? STEP_MIN : step_reg;
    assign p = cq_item.restart ? '0 : pred_reg;

    always_comb
    begin
        mag = {4'b0000, s[STEP_W-1:3]};
        if (cq_item.code[0])
        begin
            mag = mag + {3'b000, s[STEP_W-1:2]};
        end
        if (cq_item.code[1])
        begin
            mag = mag + {2'b00, s[STEP_W-1:1]};
        end
        if (cq_item.code[2])
        begin
            mag = mag + {1'b0, s};
        end
    end

    always_comb
    begin
        delta = cq_item.code[3] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        sum   = $signed({{2{p[SAMPLE_W-1]}}, p}) + delta;
        if (sum > SUM_MAX)
        begin
            pred_next = SUM_MAX[SAMPLE_W-1:0];
        end
        else if (sum < SUM_MIN)
        begin
            pred_next = SUM_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            pred_next = sum[SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        prod   = PROD_W'(s) * PROD_W'(step_factor(cq_item.code[2:0]));
        scaled = prod[PROD_W-1:STEP_SHIFT];
        if (scaled < SCALED_W'(STEP_MIN))
        begin
            step_next = STEP_MIN;
        end
        else if (scaled > SCALED_W'(STEP_MAX))
        begin
            step_next = STEP_MAX;
        end
        else
        begin
            step_next = scaled[STEP_W-1:0];
        end
    end

    assign rq_item.sample = pred_next;
    assign rq_item.last   = cq_item.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg <= '0;
            step_reg <= STEP_MIN;
        end
        else if (consume)
        begin
            pred_reg <= pred_next;
            step_reg <= step_next;
        end
    end

    `ADND_ASSERT_IMP(a_step_range, 1'b1, (step_reg >= STEP_MIN) && (step_reg <= STEP_MAX))
    `ADND_ASSERT_NEXT(a_pred_hold, !consume, $stable(pred_reg))
    `ADND_ASSERT_NEXT(a_step_hold, !consume, $stable(step_reg))

endmodule

`default_nettype wire

// ----- design/adpcm_nibble_decoder.sv -----
// ----------------------------------------------------------------------------
// ADPCM nibble decoder
// Decodes bytes of two 4-bit ADPCM codes into saturated 16-bit PCM samples.
// ----------------------------------------------------------------------------
// Input channel: a code byte with high_only and restart is taken on a clock
// edge where push is high and full is low. The high nibble is decoded first;
// with high_only set only that nibble is decoded. restart reloads the
// predictor to zero and the step size to 127 before the byte is decoded.
// Result channel: while empty is low the oldest sample is on sample and last;
// it is taken on an edge where pop is high. last marks the final sample of a
// byte.
// Each code is written into the code queue and decoded from it into the
// result queue; a low nibble waits in the front end's pending register.
// Throughput: the back end decodes one code per cycle while a code is queued and
// the result queue is not full; no byte is taken while a low nibble is pending.
// Reset clears both queues, sets the predictor to zero and the step to 127.
// If the receiver stalls, the result queue fills, the back end holds its
// state and the code queue backs up until full rises on the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module adpcm_nibble_decoder #(
    parameter int CODE_QUEUE_DEPTH   = adnd_pkg::CODE_QUEUE_DEPTH_DEF,
    parameter int RESULT_QUEUE_DEPTH = adnd_pkg::RESULT_QUEUE_DEPTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic [adnd_pkg::BYTE_W-1:0]          code_byte,
    input  wire logic                                 high_only,
    input  wire logic                                 restart,
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic signed [adnd_pkg::SAMPLE_W-1:0]      sample,
    output logic                                      last
);

    import adnd_pkg::*;

    code_item_t front_item;
    code_item_t cq_head;
    result_t    core_result;
    result_t    rq_head;
    logic       cq_push;
    logic       cq_full;
    logic       cq_empty;
    logic       cq_pop;
    logic       rq_push;
    logic       rq_full;

    adnd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .code_byte (code_byte),
        .high_only (high_only),
        .restart   (restart),
        .cq_push   (cq_push),
        .cq_item   (front_item),
        .cq_full   (cq_full)
    );

    adnd_fifo #(
        .WIDTH ($bits(code_item_t)),
        .DEPTH (CODE_QUEUE_DEPTH)
    ) u_code_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cq_push),
        .wdata (front_item),
        .full  (cq_full),
        .pop   (cq_pop),
        .rdata (cq_head),
        .empty (cq_empty)
    );

    adnd_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cq_item  (cq_head),
        .cq_empty (cq_empty),
        .cq_pop   (cq_pop),
        .rq_push  (rq_push),
        .rq_item  (core_result),
        .rq_full  (rq_full)
    );

    adnd_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RESULT_QUEUE_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .wdata (core_result),
        .full  (rq_full),
        .pop   (pop),
        .rdata (rq_head),
        .empty (empty)
    );

    assign sample = rq_head.sample;
    assign last   = rq_head.last;

endmodule

`default_nettype wire

// ----- tb/sv/adpcm_nibble_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// ADPCM nibble decoder testbench
// Drives code bytes through the input queue, decodes each nibble with its own
// predictor and step state, and checks every sample and last flag in order.
// Random idle bursts on both sides, a long receiver hold and drained pauses
// between phases exercise back pressure and restart handling.
// ----------------------------------------------------------------------------
`default_nettype none

module adpcm_nibble_decoder_tb;

    localparam int CLK_HALF    = 6;
    localparam int RESET_CYCLES = 7;
    localparam int LONG_HOLD   = 150;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 6;
    localparam int PRED_HI     = 32767;
    localparam int PRED_LO     = -32768;
    localparam int STEP_LO     = 127;
    localparam int STEP_HI     = 24576;

    typedef struct {
        logic [adnd_pkg::BYTE_W-1:0] code_byte;
        logic                        high_only;
        logic                        restart;
    } code_byte_t;

    typedef struct {
        logic signed [adnd_pkg::SAMPLE_W-1:0] sample;
        logic                                 last;
    } pcm_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic [adnd_pkg::BYTE_W-1:0] code_byte = '0;
    logic high_only = 1'b0;
    logic restart = 1'b0;
    logic pop = 1'b0;
    logic full;
    logic empty;
    logic signed [adnd_pkg::SAMPLE_W-1:0] sample;
    logic last;

    code_byte_t byte_q[$];
    pcm_t pcm_expect_q[$];

    int pred_acc = 0;
    int step_acc = STEP_LO;
    int errors = 0;
    int tx_odds = 8;
    int rx_odds = 8;
    int hold_asks = 0;
    int hold_seen = 0;
    logic took_byte = 1'b0;
    logic drift_neg = 1'b0;

    adpcm_nibble_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .code_byte (code_byte),
        .high_only (high_only),
        .restart   (restart),
        .empty     (empty),
        .pop       (pop),
        .sample    (sample),
        .last      (last)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    function automatic int adapt_factor(input logic [2:0] mag_bits);
        int f;
        case (mag_bits)
            3'd4:    f = 'h4CC0;
            3'd5:    f = 'h6640;
            3'd6:    f = 'h8000;
            3'd7:    f = 'h9980;
            default: f = 'h3980;
        endcase
        return f;
    endfunction

    task automatic decode_nibble(input logic [3:0] code, input logic is_last);
        int mag;
        int next_step;
        pcm_t res;
        mag = step_acc >> 3;
        if (code[0])
            mag += step_acc >> 2;
        if (code[1])
            mag += step_acc >> 1;
        if (code[2])
            mag += step_acc;
        pred_acc = code[3] ? pred_acc - mag : pred_acc + mag;
        if (pred_acc > PRED_HI)
            pred_acc = PRED_HI;
        if (pred_acc < PRED_LO)
            pred_acc = PRED_LO;
        next_step = (step_acc * adapt_factor(code[2:0])) >>> adnd_pkg::STEP_SHIFT;
        if (next_step < STEP_LO)
            next_step = STEP_LO;
        if (next_step > STEP_HI)
            next_step = STEP_HI;
        step_acc = next_step;
        res.sample = pred_acc[adnd_pkg::SAMPLE_W-1:0];
        res.last = is_last;
        pcm_expect_q.push_back(res);
    endtask

    task automatic decode_byte(input code_byte_t item);
        if (item.restart)
        begin
            pred_acc = 0;
            step_acc = STEP_LO;
        end
        decode_nibble(item.code_byte[7:4], item.high_only);
        if (!item.high_only)
            decode_nibble(item.code_byte[3:0], 1'b1);
    endtask

    int tx_gap = 0;

    always @(negedge clk)
    begin : sender
        code_byte_t nxt;
        logic drive_push;
        drive_push = push;
        if (rst_n)
        begin
            if (push && took_byte)
                drive_push = 1'b0;
            if (!drive_push && tx_gap > 0)
            begin
                tx_gap--;
            end
            else if (!drive_push && byte_q.size() > 0)
            begin
                nxt = byte_q.pop_front();
                code_byte <= nxt.code_byte;
                high_only <= nxt.high_only;
                restart <= nxt.restart;
                drive_push = 1'b1;
                if (tx_odds > 0 && $urandom_range(1, tx_odds) == 1)
                    tx_gap = $urandom_range(1, 18);
            end
        end
        push <= drive_push;
    end

    int rx_hold = 0;
    int rx_gap = 0;

    always @(negedge clk)
    begin : receiver
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                rx_hold = LONG_HOLD;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                pop <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if (rx_odds > 0 && $urandom_range(1, rx_odds) == 1)
                    rx_gap = $urandom_range(1, 18);
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        code_byte_t item;
        pcm_t want;
        took_byte = rst_n && push && !full;
        if (took_byte)
        begin
            item.code_byte = code_byte;
            item.high_only = high_only;
            item.restart = restart;
            decode_byte(item);
        end
        if (rst_n && pop && !empty)
        begin
            if (pcm_expect_q.size() == 0)
            begin
                $display("%0t: unexpected transaction, sample %0d last %0b",
                         $time, sample, last);
                errors++;
            end
            else
            begin
                want = pcm_expect_q.pop_front();
                if (sample !== want.sample)
                begin
                    $display("%0t: sample mismatch, expected %0d, actual %0d",
                             $time, want.sample, sample);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $time, want.last, last);
                    errors++;
                end
            end
        end
    end

    int stall_cycles = 0;

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("adpcm_nibble_decoder_tb: errors");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic ho, input logic rs);
        code_byte_t item;
        item.code_byte = b;
        item.high_only = ho;
        item.restart = rs;
        byte_q.push_back(item);
    endtask

    task automatic queue_random(input int count);
        logic [7:0] b;
        int sel;
        repeat (count)
        begin
            if ($urandom_range(0, 29) == 0)
                drift_neg = ~drift_neg;
            b = 8'($urandom_range(0, 255));
            sel = $urandom_range(0, 19);
            if (sel < 5)
                b = {drift_neg, b[6:4] | 3'b110, drift_neg, b[2:0] | 3'b110};
            else if (sel < 8)
                b = b & 8'h88;
            queue_byte(b, $urandom_range(0, 7) == 0, $urandom_range(0, 39) == 0);
        end
    endtask

    task automatic wait_drained();
        while (byte_q.size() != 0 || push || pcm_expect_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h01, 1'b0, 1'b0);
        queue_byte(8'h23, 1'b0, 1'b0);
        queue_byte(8'h45, 1'b0, 1'b0);
        queue_byte(8'h67, 1'b0, 1'b0);
        queue_byte(8'h89, 1'b0, 1'b0);
        queue_byte(8'hAB, 1'b0, 1'b0);
        queue_byte(8'hCD, 1'b0, 1'b0);
        queue_byte(8'hEF, 1'b1, 1'b0);
        queue_byte(8'h5A, 1'b1, 1'b1);
        queue_byte(8'h77, 1'b0, 1'b1);
        repeat (5) queue_byte(8'h77, 1'b0, 1'b0);
        repeat (8) queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'h80, 1'b1, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b1);
        wait_drained();

        hold_asks++;
        queue_random(60);
        wait_drained();

        tx_odds = 4;
        rx_odds = 30;
        queue_random(400);
        wait_drained();

        tx_odds = 30;
        rx_odds = 4;
        queue_random(400);
        wait_drained();

        tx_odds = 8;
        rx_odds = 8;
        queue_random(400);
        wait_drained();

        tx_odds = 3;
        rx_odds = 3;
        queue_random(400);
        wait_drained();

        tx_odds = 0;
        rx_odds = 0;
        queue_random(120);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pcm_expect_q.size() == 0)
            $display("adpcm_nibble_decoder_tb: clean");
        else
            $display("adpcm_nibble_decoder_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
